### rtl/afs_pkg.sv
// Shared types and constants for the alignment flag statistics block.
// Holds flag bit positions, statistic numbers, command codes and the bump mask type.
package afs_pkg;

  localparam int unsigned FLAG_W       = 12;
  localparam int unsigned ID_W         = 32;
  localparam int unsigned MAPQ_W       = 8;
  localparam int unsigned CMD_W        = 2;
  localparam int unsigned SEL_W        = 5;
  localparam int unsigned NUM_STATS    = 16;
  localparam int unsigned NUM_COUNTERS = 32;
  localparam int unsigned OUT_VALUE_W  = 48;

  localparam logic [CMD_W-1:0] CMD_COUNT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam int unsigned FB_PAIRED    = 0;
  localparam int unsigned FB_PROPER    = 1;
  localparam int unsigned FB_UNMAP     = 2;
  localparam int unsigned FB_MUNMAP    = 3;
  localparam int unsigned FB_READ1     = 6;
  localparam int unsigned FB_READ2     = 7;
  localparam int unsigned FB_SECONDARY = 8;
  localparam int unsigned FB_QCFAIL    = 9;
  localparam int unsigned FB_DUP       = 10;
  localparam int unsigned FB_SUPP      = 11;

  localparam int unsigned S_TOTAL     = 0;
  localparam int unsigned S_MAPPED    = 1;
  localparam int unsigned S_PAIRED    = 2;
  localparam int unsigned S_BOTHMAP   = 3;
  localparam int unsigned S_PROPER    = 4;
  localparam int unsigned S_SINGLE    = 5;
  localparam int unsigned S_READ1     = 6;
  localparam int unsigned S_READ2     = 7;
  localparam int unsigned S_DUP       = 8;
  localparam int unsigned S_DIFFCHR   = 9;
  localparam int unsigned S_DIFFHIGH  = 10;
  localparam int unsigned S_SECONDARY = 11;
  localparam int unsigned S_SUPP      = 12;
  localparam int unsigned S_PRIMARY   = 13;
  localparam int unsigned S_PMAPPED   = 14;
  localparam int unsigned S_PDUP      = 15;

  typedef struct packed {
    logic [NUM_STATS-1:0] mask;
    logic                 bank;
  } bump_t;

endpackage

### rtl/afs_classify.sv
// Classifies one alignment record into the set of statistics it increments.
// Depends on afs_pkg for flag bit positions, statistic numbers and bump_t.
module afs_classify (
  input  logic [afs_pkg::FLAG_W-1:0] flag,
  input  logic [afs_pkg::ID_W-1:0]   ref_id,
  input  logic [afs_pkg::ID_W-1:0]   mate_ref_id,
  input  logic [afs_pkg::MAPQ_W-1:0] mapping_quality,
  input  logic [afs_pkg::MAPQ_W-1:0] threshold,
  output afs_pkg::bump_t             bump
);

  logic secondary, supp, primary, paired_p, unmap, munmap, dup, both_map, diff_chr;

  always_comb begin
    secondary = flag[afs_pkg::FB_SECONDARY];
    supp      = flag[afs_pkg::FB_SUPP];
    unmap     = flag[afs_pkg::FB_UNMAP];
    munmap    = flag[afs_pkg::FB_MUNMAP];
    dup       = flag[afs_pkg::FB_DUP];
    primary   = !secondary && !supp;
    paired_p  = primary && flag[afs_pkg::FB_PAIRED];
    both_map  = paired_p && !unmap && !munmap;
    diff_chr  = both_map && (ref_id != mate_ref_id);

    bump.bank = flag[afs_pkg::FB_QCFAIL];
    bump.mask = '0;
    bump.mask[afs_pkg::S_TOTAL]     = 1'b1;
    bump.mask[afs_pkg::S_MAPPED]    = !unmap;
    bump.mask[afs_pkg::S_PAIRED]    = paired_p;
    bump.mask[afs_pkg::S_BOTHMAP]   = both_map;
    bump.mask[afs_pkg::S_PROPER]    = paired_p && flag[afs_pkg::FB_PROPER] && !unmap;
    bump.mask[afs_pkg::S_SINGLE]    = paired_p && munmap && !unmap;
    bump.mask[afs_pkg::S_READ1]     = paired_p && flag[afs_pkg::FB_READ1];
    bump.mask[afs_pkg::S_READ2]     = paired_p && flag[afs_pkg::FB_READ2];
    bump.mask[afs_pkg::S_DUP]       = dup;
    bump.mask[afs_pkg::S_DIFFCHR]   = diff_chr;
    bump.mask[afs_pkg::S_DIFFHIGH]  = diff_chr && (mapping_quality >= threshold);
    bump.mask[afs_pkg::S_SECONDARY] = secondary;
    bump.mask[afs_pkg::S_SUPP]      = !secondary && supp;
    bump.mask[afs_pkg::S_PRIMARY]   = primary;
    bump.mask[afs_pkg::S_PMAPPED]   = primary && !unmap;
    bump.mask[afs_pkg::S_PDUP]      = primary && dup;
  end

endmodule

### rtl/afs_counter_bank.sv
// Bank of saturating statistic counters with clear and a single read port.
// Depends on afs_pkg for counter counts, widths and bump_t.
module afs_counter_bank #(
  parameter int unsigned COUNT_WIDTH = 48
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            count_en,
  input  logic                            clear_en,
  input  afs_pkg::bump_t                  bump,
  input  logic [afs_pkg::SEL_W-1:0]       rd_sel,
  output logic [afs_pkg::OUT_VALUE_W-1:0] rd_value
);

  logic [COUNT_WIDTH-1:0] cnt_r   [afs_pkg::NUM_COUNTERS];
  logic [COUNT_WIDTH-1:0] cnt_nxt [afs_pkg::NUM_COUNTERS];
  logic [COUNT_WIDTH-1:0] rd_raw;

  always_comb begin
    for (int i = 0; i < afs_pkg::NUM_COUNTERS; i++) begin
      cnt_nxt[i] = cnt_r[i];
      if (clear_en) begin
        cnt_nxt[i] = '0;
      end else if (count_en && bump.mask[i / 2] && (bump.bank == 1'(i % 2))
                   && (cnt_r[i] != '1)) begin
        cnt_nxt[i] = cnt_r[i] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < afs_pkg::NUM_COUNTERS; i++) begin
      if (!rst_n) begin
        cnt_r[i] <= '0;
      end else begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

  assign rd_raw = cnt_r[rd_sel];

  generate
    if (COUNT_WIDTH > afs_pkg::OUT_VALUE_W) begin : g_wide
      assign rd_value = (|rd_raw[COUNT_WIDTH-1:afs_pkg::OUT_VALUE_W]) ? '1 :
                        rd_raw[afs_pkg::OUT_VALUE_W-1:0];
    end else if (COUNT_WIDTH < afs_pkg::OUT_VALUE_W) begin : g_narrow
      assign rd_value = {{(afs_pkg::OUT_VALUE_W - COUNT_WIDTH){1'b0}}, rd_raw};
    end else begin : g_exact
      assign rd_value = rd_raw;
    end
  endgenerate

endmodule

### rtl/alignment_flag_statistics.sv
// Top level of the alignment flag statistics block: input register, classifier,
// counter bank and output register. Depends on afs_pkg, afs_classify, afs_counter_bank.
//
//  Port group  Direction  Payload
//  in_*        slave      tdata: cmd, flag, ref_id, mate_ref_id, mapping_quality, counter_select
//  out_*       master     tdata: counter_id, counter_value (read command only)
//  cfg_*       slave      data: high_quality_threshold
//
// One item is taken per cycle while no stalled read result holds the input. An item is registered
// on transfer; a count or clear is classified and applied to the counters in the following cycle,
// and a read result is registered in the output register. Reset clears all counters and loads the
// threshold with 5; no clearing pass is needed. A stalled read result holds a following read in
// the input register, and with it the input; counts and clears pass while no read waits there.
module alignment_flag_statistics #(
  parameter int unsigned COUNT_WIDTH = 48
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] cmd, [13:2] flag, [45:14] ref_id, [77:46] mate_ref_id,
  // [85:78] mapping_quality, [90:86] counter_select, [95:91] zero
  input  logic [95:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [4:0] counter_id, [52:5] counter_value, [55:53] zero
  output logic [55:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic                             s1_valid_r;
  logic [afs_pkg::CMD_W-1:0]        cmd_r;
  logic [afs_pkg::FLAG_W-1:0]       flag_r;
  logic [afs_pkg::ID_W-1:0]         ref_id_r;
  logic [afs_pkg::ID_W-1:0]         mate_ref_id_r;
  logic [afs_pkg::MAPQ_W-1:0]       mapq_r;
  logic [afs_pkg::SEL_W-1:0]        sel_r;
  logic [afs_pkg::MAPQ_W-1:0]       threshold_r;
  logic                             out_valid_r;
  logic [afs_pkg::SEL_W-1:0]        out_id_r;
  logic [afs_pkg::OUT_VALUE_W-1:0]  out_value_r;

  logic                             s1_is_read;
  logic                             s1_adv;
  logic                             in_xfer;
  afs_pkg::bump_t                   bump;
  logic [afs_pkg::OUT_VALUE_W-1:0]  rd_value;

  assign s1_is_read = (cmd_r == afs_pkg::CMD_READ);
  assign s1_adv     = s1_valid_r && (!s1_is_read || !out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_adv;
  assign in_xfer    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      threshold_r <= 8'd5;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv && s1_is_read) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        threshold_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r         <= in_tdata[1:0];
      flag_r        <= in_tdata[13:2];
      ref_id_r      <= in_tdata[45:14];
      mate_ref_id_r <= in_tdata[77:46];
      mapq_r        <= in_tdata[85:78];
      sel_r         <= in_tdata[90:86];
    end
    if (s1_adv && s1_is_read) begin
      out_id_r    <= sel_r;
      out_value_r <= rd_value;
    end
  end

  afs_classify u_classify (
    .flag            (flag_r),
    .ref_id          (ref_id_r),
    .mate_ref_id     (mate_ref_id_r),
    .mapping_quality (mapq_r),
    .threshold       (threshold_r),
    .bump            (bump)
  );

  afs_counter_bank #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_counter_bank (
    .clk      (clk),
    .rst_n    (rst_n),
    .count_en (s1_adv && (cmd_r == afs_pkg::CMD_COUNT)),
    .clear_en (s1_adv && (cmd_r == afs_pkg::CMD_CLEAR)),
    .bump     (bump),
    .rd_sel   (sel_r),
    .rd_value (rd_value)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_value_r, out_id_r};

endmodule

### tb/tb_top.sv
// Self-checking testbench for alignment_flag_statistics: drives records, reads and clears,
// predicts every counter read in step with the stream and checks each result transfer.
// Depends on afs_pkg and the alignment_flag_statistics RTL only.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam logic [afs_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [63:0] OUT_LIMIT = (64'd1 << afs_pkg::OUT_VALUE_W) - 64'd1;

  typedef struct {
    logic [afs_pkg::SEL_W-1:0]       id;
    logic [afs_pkg::OUT_VALUE_W-1:0] value;
  } counter_read_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  logic [COUNT_W-1:0] stat_count [afs_pkg::NUM_COUNTERS];
  logic [7:0]         hq_threshold = 8'd5;
  counter_read_t      expected_reads [$];

  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_cycles = 0;

  alignment_flag_statistics #(
    .COUNT_WIDTH(COUNT_W)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    foreach (stat_count[i]) stat_count[i] = '0;
  end

  // Prediction of the counter bank.

  function automatic void bump_counter(int unsigned stat, logic bank);
    int unsigned idx;
    idx = stat * 2 + bank;
    if (stat_count[idx] != COUNT_MAX) stat_count[idx] = stat_count[idx] + 1'b1;
  endfunction

  function automatic void tally_record(logic [afs_pkg::FLAG_W-1:0] flag,
                                       logic [afs_pkg::ID_W-1:0] rid,
                                       logic [afs_pkg::ID_W-1:0] mrid,
                                       logic [afs_pkg::MAPQ_W-1:0] mq);
    logic bank;
    logic unmapped;
    logic mate_unmapped;
    bank = flag[afs_pkg::FB_QCFAIL];
    unmapped = flag[afs_pkg::FB_UNMAP];
    mate_unmapped = flag[afs_pkg::FB_MUNMAP];
    bump_counter(afs_pkg::S_TOTAL, bank);
    if (flag[afs_pkg::FB_SECONDARY]) begin
      bump_counter(afs_pkg::S_SECONDARY, bank);
    end else if (flag[afs_pkg::FB_SUPP]) begin
      bump_counter(afs_pkg::S_SUPP, bank);
    end else begin
      bump_counter(afs_pkg::S_PRIMARY, bank);
      if (flag[afs_pkg::FB_PAIRED]) begin
        bump_counter(afs_pkg::S_PAIRED, bank);
        if (flag[afs_pkg::FB_PROPER] && !unmapped) bump_counter(afs_pkg::S_PROPER, bank);
        if (flag[afs_pkg::FB_READ1]) bump_counter(afs_pkg::S_READ1, bank);
        if (flag[afs_pkg::FB_READ2]) bump_counter(afs_pkg::S_READ2, bank);
        if (mate_unmapped && !unmapped) bump_counter(afs_pkg::S_SINGLE, bank);
        if (!unmapped && !mate_unmapped) begin
          bump_counter(afs_pkg::S_BOTHMAP, bank);
          if (rid != mrid) begin
            bump_counter(afs_pkg::S_DIFFCHR, bank);
            if (mq >= hq_threshold) bump_counter(afs_pkg::S_DIFFHIGH, bank);
          end
        end
      end
      if (!unmapped) bump_counter(afs_pkg::S_PMAPPED, bank);
      if (flag[afs_pkg::FB_DUP]) bump_counter(afs_pkg::S_PDUP, bank);
    end
    if (!unmapped) bump_counter(afs_pkg::S_MAPPED, bank);
    if (flag[afs_pkg::FB_DUP]) bump_counter(afs_pkg::S_DUP, bank);
  endfunction

  function automatic void take_item(logic [afs_pkg::CMD_W-1:0] cmd,
                                    logic [afs_pkg::FLAG_W-1:0] flag,
                                    logic [afs_pkg::ID_W-1:0] rid,
                                    logic [afs_pkg::ID_W-1:0] mrid,
                                    logic [afs_pkg::MAPQ_W-1:0] mq,
                                    logic [afs_pkg::SEL_W-1:0] sel);
    counter_read_t rd;
    logic [63:0]   v;
    case (cmd)
      afs_pkg::CMD_COUNT: tally_record(flag, rid, mrid, mq);
      afs_pkg::CMD_READ: begin
        v = 64'(stat_count[sel]);
        if (v > OUT_LIMIT) v = OUT_LIMIT;
        rd.id = sel;
        rd.value = v[afs_pkg::OUT_VALUE_W-1:0];
        expected_reads.push_back(rd);
      end
      afs_pkg::CMD_CLEAR: begin
        foreach (stat_count[i]) stat_count[i] = '0;
      end
      default: ;
    endcase
  endfunction

  // Result checking.

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_reads
    counter_read_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_reads.size() == 0) begin
        report_mismatch("result with no read outstanding", 64'(out_tdata), 64'd0);
      end else begin
        want = expected_reads.pop_front();
        if (out_tdata[4:0] != want.id)
          report_mismatch("counter_id", 64'(out_tdata[4:0]), 64'(want.id));
        if (out_tdata[52:5] != want.value)
          report_mismatch("counter_value", 64'(out_tdata[52:5]), 64'(want.value));
        if (out_tdata[55:53] != 3'd0)
          report_mismatch("tdata padding", 64'(out_tdata[55:53]), 64'd0);
      end
    end
  end

  always @(negedge clk) begin
    if (hold_cycles != 0) begin
      out_tready = 1'b0;
      hold_cycles--;
    end else begin
      out_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Stimulus helpers; every task starts and ends just after a falling edge.

  task automatic send_item(logic [afs_pkg::CMD_W-1:0] cmd, logic [afs_pkg::FLAG_W-1:0] flag,
                           logic [afs_pkg::ID_W-1:0] rid, logic [afs_pkg::ID_W-1:0] mrid,
                           logic [afs_pkg::MAPQ_W-1:0] mq, logic [afs_pkg::SEL_W-1:0] sel);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {5'd0, sel, mq, mrid, rid, flag, cmd};
    do @(posedge clk); while (!in_tready);
    take_item(cmd, flag, rid, mrid, mq, sel);
    @(negedge clk);
  endtask

  task automatic send_record(logic [afs_pkg::FLAG_W-1:0] flag, logic [afs_pkg::ID_W-1:0] rid,
                             logic [afs_pkg::ID_W-1:0] mrid, logic [afs_pkg::MAPQ_W-1:0] mq);
    send_item(afs_pkg::CMD_COUNT, flag, rid, mrid, mq, 5'($urandom));
  endtask

  task automatic send_read(logic [afs_pkg::SEL_W-1:0] sel);
    send_item(afs_pkg::CMD_READ, 12'($urandom), $urandom, $urandom, 8'($urandom), sel);
  endtask

  task automatic send_clear();
    send_item(afs_pkg::CMD_CLEAR, 12'($urandom), $urandom, $urandom, 8'($urandom),
              5'($urandom));
  endtask

  task automatic wait_for_drain();
    in_tvalid = 1'b0;
    while (expected_reads.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_threshold(logic [7:0] value);
    wait_for_drain();
    cfg_valid = 1'b1;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    hq_threshold = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [afs_pkg::ID_W-1:0] pick_id();
    case ($urandom_range(3))
      0: return 32'hFFFF_FFFF;
      1: return 32'($urandom_range(3));
      2: return 32'h7FFF_FFFF;
      default: return $urandom & 32'h7FFF_FFFF;
    endcase
  endfunction

  task automatic send_random_record();
    logic [afs_pkg::FLAG_W-1:0] flag;
    logic [afs_pkg::ID_W-1:0]   rid;
    logic [afs_pkg::ID_W-1:0]   mrid;
    logic [afs_pkg::MAPQ_W-1:0] mq;
    flag = 12'($urandom);
    if ($urandom_range(99) < 70) begin
      flag[afs_pkg::FB_SECONDARY] = 1'b0;
      flag[afs_pkg::FB_SUPP] = 1'b0;
    end
    if ($urandom_range(99) < 70) flag[afs_pkg::FB_PAIRED] = 1'b1;
    if ($urandom_range(99) < 50) begin
      flag[afs_pkg::FB_UNMAP] = 1'b0;
      flag[afs_pkg::FB_MUNMAP] = 1'b0;
    end
    rid = pick_id();
    mrid = $urandom_range(1) ? rid : pick_id();
    if ($urandom_range(1)) mq = hq_threshold + 8'($urandom_range(2)) - 8'd1;
    else mq = 8'($urandom);
    send_record(flag, rid, mrid, mq);
  endtask

  task automatic run_random(int unsigned count);
    int unsigned n;
    int unsigned roll;
    n = 0;
    while (n < count) begin
      roll = $urandom_range(99);
      if (roll < 60) begin
        send_random_record();
        n++;
      end else if (roll < 95) begin
        send_read(5'($urandom));
        n++;
      end else if (roll < 97) begin
        send_clear();
        n++;
      end else begin
        send_item(CMD_UNUSED, 12'($urandom), $urandom, $urandom, 8'($urandom),
                  5'($urandom));
      end
    end
  endtask

  task automatic read_every_counter();
    for (int i = 0; i < afs_pkg::NUM_COUNTERS; i++) send_read(5'(i));
  endtask

  // Tests.

  task automatic test_directed_records();
    send_record(12'h000, 32'd0, 32'd0, 8'd0);
    send_record(12'h004, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0);
    send_record(12'h100, 32'd1, 32'd2, 8'd60);
    send_record(12'h800, 32'd1, 32'd1, 8'd60);
    send_record(12'h900, 32'd1, 32'd1, 8'd60);
    send_record(12'h043, 32'd2, 32'd2, 8'd60);
    send_record(12'h087, 32'd2, 32'd2, 8'd60);
    send_record(12'h009, 32'd2, 32'hFFFF_FFFF, 8'd60);
    send_record(12'h00D, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0);
    send_record(12'h001, 32'd0, 32'd1, 8'd5);
    send_record(12'h001, 32'd3, 32'd7, 8'd4);
    send_record(12'h001, 32'hFFFF_FFFF, 32'd0, 8'd255);
    send_record(12'h001, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 8'd255);
    send_record(12'h400, 32'd0, 32'd0, 8'd0);
    send_record(12'h500, 32'd0, 32'd0, 8'd0);
    send_record(12'h243, 32'd4, 32'd9, 8'd30);
    send_record(12'hFFF, 32'd4, 32'd9, 8'd255);
    // The unused command must leave every counter untouched.
    send_item(CMD_UNUSED, 12'h0FF, 32'd0, 32'd1, 8'd255, 5'd31);
  endtask

  task automatic test_read_and_clear();
    read_every_counter();
    send_clear();
    send_read(5'd0);
    send_read(5'd31);
    send_record(12'h200, 32'd0, 32'd0, 8'd0);
    send_read(5'd1);
    send_read(5'd3);
  endtask

  task automatic test_threshold_extremes();
    write_threshold(8'd0);
    send_record(12'h001, 32'd0, 32'd1, 8'd0);
    send_record(12'h201, 32'd0, 32'd1, 8'd0);
    send_read(5'(afs_pkg::S_DIFFHIGH * 2));
    send_read(5'(afs_pkg::S_DIFFHIGH * 2 + 1));
    write_threshold(8'd255);
    send_record(12'h001, 32'd0, 32'd1, 8'd254);
    send_record(12'h001, 32'd0, 32'd1, 8'd255);
    send_read(5'(afs_pkg::S_DIFFHIGH * 2));
    send_read(5'(afs_pkg::S_DIFFCHR * 2));
    write_threshold(8'd5);
  endtask

  task automatic test_output_backpressure();
    wait_for_drain();
    hold_cycles = 300;
    for (int i = 0; i < 60; i++) begin
      if (i % 3 == 0) send_random_record();
      else send_read(5'($urandom));
    end
    wait_for_drain();
  endtask

  task automatic test_random_traffic();
    int unsigned send_pct [4] = '{0, 46, 0, 37};
    int unsigned recv_pct [4] = '{0, 0, 46, 37};
    logic [7:0]  thresholds [4];
    thresholds = '{8'($urandom), 8'd0, 8'd255, 8'($urandom)};
    for (int p = 0; p < 4; p++) begin
      write_threshold(thresholds[p]);
      send_idle_pct = send_pct[p];
      recv_stall_pct = recv_pct[p];
      run_random(175);
      wait_for_drain();
      run_random(170);
    end
  endtask

  task automatic finish_run();
    int unsigned waited;
    in_tvalid = 1'b0;
    waited = 0;
    while (expected_reads.size() != 0 && waited < 10000) begin
      @(negedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_reads.size() != 0)
      report_mismatch("reads left without a result", 64'd0, 64'(expected_reads.size()));
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed_records();
    test_read_and_clear();
    test_threshold_extremes();
    test_output_backpressure();
    test_random_traffic();
    finish_run();
  end

endmodule
